/* rtl/ffcd_pkg.sv */
// Shared constants, types and index function for the flagged frame channel demux.
`default_nettype none

package ffcd_pkg;

  localparam int unsigned FrameLen   = 12;
  localparam int unsigned PairCount  = FrameLen / 2;
  localparam int unsigned WordW      = 16;
  localparam int unsigned SampleW    = WordW - 1;
  localparam int unsigned PosW       = 4;
  localparam int unsigned PairCntW   = 3;
  localparam int unsigned NoRotAlign = 10;
  localparam int unsigned LeadSlots  = 4;

  localparam logic [PosW-1:0]     LastPos  = PosW'(FrameLen - 1);
  localparam logic [PairCntW-1:0] LastPair = PairCntW'(PairCount - 1);

  typedef enum logic [1:0] {
    CH_A = 2'd0,
    CH_B = 2'd1,
    CH_C = 2'd2
  } chan_e;

  // Word index within the frame that feeds emission slot `slot` for alignment n.
  // Slots 0..3 are words n..n+3; slots 4..11 are the rotated channel C words.
  function automatic logic [PosW-1:0] src_index(input logic [PosW-1:0] n,
                                                input logic [PosW-1:0] slot);
    logic [2:0]  rot;
    logic [2:0]  k;
    logic [PosW:0] idx;
    rot = (n == PosW'(NoRotAlign)) ? 3'd0 : 3'(3'd0 - n[2:0]);
    k   = 3'(slot - PosW'(LeadSlots));
    if (slot < PosW'(LeadSlots)) begin
      idx = {1'b0, n} + {1'b0, slot};
    end else begin
      idx = {1'b0, n} + (PosW+1)'(LeadSlots) + {2'b00, 3'(k + rot)};
    end
    if (idx >= (PosW+1)'(FrameLen)) begin
      idx = idx - (PosW+1)'(FrameLen);
    end
    return idx[PosW-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/flagged_frame_channel_demux.sv */
// Top level: flagged ADC frame demultiplexer into three I/Q channels.
`default_nettype none

// Takes one 16-bit ADC word per cycle, twelve words to a frame. Alignment n is
// the index of the last word whose bit 15 is set (0 if none), tracked as the
// words arrive. On the twelfth word the frame is reordered into emission order
// and loaded into a 12-entry output shift register; six results follow, one per
// cycle while out_stall_i is low, starting the cycle after the twelfth word:
// channel A from words n and n+1, B from n+2 and n+3, then four C pairs. Words
// become Q1.15 by dropping the flag (word << 1). Input words are taken every
// cycle; only the twelfth word of a frame stalls, and only while the previous
// frame still has results waiting in the output shift register.
module flagged_frame_channel_demux
  import ffcd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [WordW-1:0]        raw_word_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [1:0]                   channel_o,
  output logic signed [WordW-1:0]      in_phase_o,
  output logic signed [WordW-1:0]      quadrature_o,
  output logic [PosW-1:0]              alignment_o,
  output logic                         alignment_changed_o,
  output logic                         frame_last_o
);

  logic [SampleW-1:0]  frame_q [FrameLen-1];
  logic [SampleW-1:0]  slot_q  [FrameLen];
  logic [SampleW-1:0]  slot_d  [FrameLen];
  logic [PosW-1:0]     pos_q, pos_d;
  logic [PosW-1:0]     run_n_q, run_n_d;
  logic [PosW-1:0]     prev_n_q;
  logic [PosW-1:0]     align_q;
  logic                changed_q;
  logic                busy_q, busy_d;
  logic [PairCntW-1:0] pair_q, pair_d;
  logic [PosW-1:0]     n_d;
  logic                in_acc, out_acc, frame_done;
  chan_e               chan;

  assign in_stall_o = (pos_q >= LastPos) && busy_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = busy_q && !out_stall_i;
  assign frame_done = in_acc && (pos_q >= LastPos);

  // alignment of the frame completing with this word
  assign n_d = raw_word_i[WordW-1] ? LastPos : run_n_q;

  always_comb begin
    pos_d   = pos_q;
    run_n_d = run_n_q;
    if (in_acc) begin
      if (frame_done) begin
        pos_d   = '0;
        run_n_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
        if (raw_word_i[WordW-1]) begin
          run_n_d = pos_q;
        end
      end
    end
  end

  always_comb begin
    logic [PosW-1:0] src;
    for (int j = 0; j < FrameLen; j++) begin
      src = src_index(n_d, PosW'(j));
      if (src >= LastPos) begin
        slot_d[j] = raw_word_i[SampleW-1:0];
      end else begin
        slot_d[j] = frame_q[src];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    pair_d = pair_q;
    if (frame_done) begin
      busy_d = 1'b1;
      pair_d = '0;
    end else if (out_acc) begin
      pair_d = pair_q + PairCntW'(1);
      if (pair_q == LastPair) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      run_n_q   <= '0;
      prev_n_q  <= '0;
      busy_q    <= 1'b0;
      pair_q    <= '0;
      changed_q <= 1'b0;
      align_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      run_n_q <= run_n_d;
      busy_q  <= busy_d;
      pair_q  <= pair_d;
      if (frame_done) begin
        prev_n_q  <= n_d;
        align_q   <= n_d;
        changed_q <= (n_d != prev_n_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !frame_done) begin
      frame_q[pos_q] <= raw_word_i[SampleW-1:0];
    end
    if (frame_done) begin
      slot_q <= slot_d;
    end else if (out_acc) begin
      for (int j = 0; j < FrameLen - 2; j++) begin
        slot_q[j] <= slot_q[j+2];
      end
    end
  end

  always_comb begin
    case (pair_q)
      3'd0:    chan = CH_A;
      3'd1:    chan = CH_B;
      default: chan = CH_C;
    endcase
  end

  assign out_valid_o         = busy_q;
  assign channel_o           = chan;
  assign in_phase_o          = {slot_q[0], 1'b0};
  assign quadrature_o        = {slot_q[1], 1'b0};
  assign alignment_o         = align_q;
  assign alignment_changed_o = changed_q;
  assign frame_last_o        = (pair_q == LastPair);

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("word position out of range");

  a_pair_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pair_q <= LastPair)
    else $error("pair counter out of range");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> busy_q && pair_q == '0 && pos_q == '0)
    else $error("frame completion did not start emission");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && pair_q == LastPair) |=> !busy_q)
    else $error("emission continued past last pair");

  a_align_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> align_q <= LastPos)
    else $error("alignment out of range");

endmodule

`default_nettype wire

/* tb/flagged_frame_channel_demux_test.sv */
// Self-checking testbench for the flagged frame channel demux.
module flagged_frame_channel_demux_test;
  import ffcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NoFlag       = FrameLen;  // frame without any flagged word
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned RandomFrames = 25;
  localparam int unsigned DrainCycles  = 16;

  typedef struct {
    chan_e                   channel;
    logic signed [WordW-1:0] in_phase;
    logic signed [WordW-1:0] quadrature;
    logic [PosW-1:0]         alignment;
    logic                    alignment_changed;
    logic                    frame_last;
  } iq_result_t;

  class frame_demux_scoreboard;
    logic [WordW-1:0] frame_words[FrameLen];
    int unsigned      word_pos;
    logic [PosW-1:0]  prev_align;
    iq_result_t       iq_expected_q[$];
    int unsigned      mismatches;

    function new();
      word_pos   = 0;
      prev_align = '0;
      mismatches = 0;
    endfunction

    function logic [WordW-1:0] q15_at(int unsigned idx);
      return {frame_words[idx % FrameLen][WordW-2:0], 1'b0};
    endfunction

    // Stores one accepted word; the twelfth word of a frame yields six pairs.
    function void note_word(logic [WordW-1:0] w);
      int unsigned n;
      int unsigned rot;
      int unsigned order[FrameLen];
      logic        changed;
      iq_result_t  r;
      frame_words[word_pos] = w;
      if (word_pos < FrameLen - 1) begin
        word_pos++;
        return;
      end
      word_pos = 0;
      n = 0;
      for (int k = 0; k < FrameLen; k++) begin
        if (frame_words[k][WordW-1]) n = k;
      end
      changed    = (PosW'(n) != prev_align);
      prev_align = PosW'(n);
      rot = (n == NoRotAlign) ? 0 : (16 - n) % 8;
      for (int k = 0; k < 4; k++) order[k] = n + k;
      for (int k = 0; k < 8; k++) order[4 + k] = n + 4 + ((k + rot) % 8);
      for (int p = 0; p < PairCount; p++) begin
        r.channel           = (p == 0) ? CH_A : (p == 1) ? CH_B : CH_C;
        r.in_phase          = q15_at(order[2*p]);
        r.quadrature        = q15_at(order[2*p + 1]);
        r.alignment         = PosW'(n);
        r.alignment_changed = changed;
        r.frame_last        = (p == PairCount - 1);
        iq_expected_q       = {iq_expected_q, r};
      end
    endfunction

    function void check_result(iq_result_t got);
      iq_result_t exp;
      if (iq_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result: ch %0d i %0d q %0d align %0d chg %0b last %0b",
                   got.channel, got.in_phase, got.quadrature, got.alignment,
                   got.alignment_changed, got.frame_last);
        return;
      end
      exp = iq_expected_q.pop_front();
      if (got.channel !== exp.channel || got.in_phase !== exp.in_phase ||
          got.quadrature !== exp.quadrature || got.alignment !== exp.alignment ||
          got.alignment_changed !== exp.alignment_changed ||
          got.frame_last !== exp.frame_last) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected: ch %0d i %0d q %0d align %0d chg %0b last %0b",
                   exp.channel, exp.in_phase, exp.quadrature, exp.alignment,
                   exp.alignment_changed, exp.frame_last);
          $display("  actual:   ch %0d i %0d q %0d align %0d chg %0b last %0b",
                   got.channel, got.in_phase, got.quadrature, got.alignment,
                   got.alignment_changed, got.frame_last);
        end
      end
    endfunction

    function void close_out();
      if (iq_expected_q.size() != 0) begin
        mismatches++;
        $display("%0d expected results never arrived", iq_expected_q.size());
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [WordW-1:0]        raw_word_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [1:0]              channel_o;
  logic signed [WordW-1:0] in_phase_o;
  logic signed [WordW-1:0] quadrature_o;
  logic [PosW-1:0]         alignment_o;
  logic                    alignment_changed_o;
  logic                    frame_last_o;

  bit                      calm = 1'b0;  // no idling on either side while set
  frame_demux_scoreboard   sb = new();

  flagged_frame_channel_demux u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .raw_word_i          (raw_word_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .channel_o           (channel_o),
    .in_phase_o          (in_phase_o),
    .quadrature_o        (quadrature_o),
    .alignment_o         (alignment_o),
    .alignment_changed_o (alignment_changed_o),
    .frame_last_o        (frame_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 29);
  end

  always @(posedge clk_i) begin
    iq_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.channel           = chan_e'(channel_o);
      got.in_phase          = in_phase_o;
      got.quadrature        = quadrature_o;
      got.alignment         = alignment_o;
      got.alignment_changed = alignment_changed_o;
      got.frame_last        = frame_last_o;
      sb.check_result(got);
    end
  end

  task automatic send_word(input logic [WordW-1:0] w);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(w);
  endtask

  // Last flagged word at align (NoFlag: none), earlier flags scattered at random.
  // A noisy frame puts random flags everywhere.
  task automatic send_frame(input int unsigned align, input bit noisy);
    logic [WordW-1:0] w;
    for (int k = 0; k < FrameLen; k++) begin
      w = WordW'($urandom_range(32'h7FFF));
      if (noisy)
        w[WordW-1] = 1'($urandom_range(1));
      else if (k == align)
        w[WordW-1] = 1'b1;
      else if (k < align && align != NoFlag)
        w[WordW-1] = ($urandom_range(3) == 0);
      send_word(w);
    end
  endtask

  initial begin
    logic [WordW-1:0] edge_words[FrameLen];
    int unsigned      align;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    raw_word_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Field extremes; last flag on word 10, where channel C is not rotated.
    edge_words = '{16'hFFFF, 16'h7FFF, 16'h0000, 16'h8000, 16'h4000, 16'hBFFF,
                   16'h0001, 16'h8001, 16'h2AAA, 16'h5555, 16'hD555, 16'h7FFE};
    foreach (edge_words[k]) send_word(edge_words[k]);
    // No flag at all: alignment falls back to zero.
    for (int k = 0; k < FrameLen; k++) send_word(WordW'(k * 16'h1111) & 16'h7FFF);

    align = NoFlag;
    for (int f = 0; f < RandomFrames; f++) begin
      calm = (f >= 14 && f < 20);
      if (f <= NoFlag)
        align = f;
      else if ($urandom_range(2) != 0)
        align = $urandom_range(NoFlag);
      send_frame(align, (f > NoFlag) && ($urandom_range(4) == 0));
    end
    calm = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.iq_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    sb.close_out();
    if (sb.mismatches == 0)
      $display("flagged_frame_channel_demux_test passed");
    else
      $display("flagged_frame_channel_demux_test failed");
    $finish;
  end

  initial begin
    #500us;
    $display("flagged_frame_channel_demux_test failed");
    $finish;
  end

endmodule
